[rtl/emlbc_pkg.sv]
// ---------------------------------------------------------------------------
// emlbc_pkg
// shared types, constants and lattice tables for the collision block
// ---------------------------------------------------------------------------
`default_nettype none
package emlbc_pkg;
   localparam int PopWidth = 32;
   localparam int AccWidth = 40;
   localparam int NumPop = 49;
   localparam int ZLimit = 4096;
   localparam int SlotWidth = 6;
   localparam int ZWidth = 12;
   localparam int AddrWidth = 4;

   localparam logic [AddrWidth-1:0] RegInvPermLower = 4'd0;
   localparam logic [AddrWidth-1:0] RegInvPermUpper = 4'd4;
   localparam logic [AddrWidth-1:0] RegInterfaceZ = 4'd8;
   localparam logic [AddrWidth-1:0] RegRelaxRate = 4'd12;

   typedef logic signed [AccWidth-1:0] acc_type;
   typedef logic signed [PopWidth-1:0] pop_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic emit;
      logic [SlotWidth-1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic ready;
   } stat_type;

   function automatic int vel(input int p, input int i, input int a);
      int v;
      v = 0;
      case (p)
         0: begin
            case (a)
               0: v = (i == 0 || i == 3) ? 1 : -1;
               1: v = (i == 0 || i == 1) ? 1 : -1;
               default: v = 0;
            endcase
         end
         1: begin
            case (a)
               0: v = (i == 0 || i == 3) ? 1 : -1;
               2: v = (i == 0 || i == 1) ? 1 : -1;
               default: v = 0;
            endcase
         end
         default: begin
            case (a)
               1: v = (i == 0 || i == 3) ? 1 : -1;
               2: v = (i == 0 || i == 1) ? 1 : -1;
               default: v = 0;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic int e2c(input int p, input int i, input int j, input int a);
      return vel(p, (i + (j != 0 ? 3 : 1)) % 4, a);
   endfunction

   function automatic int b2c(input int p, input int i, input int j, input int a);
      int a1;
      int a2;
      a1 = (a + 1) % 3;
      a2 = (a + 2) % 3;
      return vel(p, i, a1) * e2c(p, i, j, a2) - vel(p, i, a2) * e2c(p, i, j, a1);
   endfunction

   // coefficient of slot k on axis a; is_b selects the magnetic vector
   function automatic logic signed [2:0] coef(input logic [SlotWidth-1:0] k,
                                              input logic is_b, input logic [1:0] a);
      int v;
      v = 0;
      for (int s = 1; s < NumPop; s++) begin
         for (int x = 0; x < 3; x++) begin
            if (int'(k) == s && int'(a) == x) begin
               if (is_b) v = b2c(((s - 1) % 24) / 8, ((s - 1) % 8) / 2, (s - 1) % 2, x);
               else v = e2c(((s - 1) % 24) / 8, ((s - 1) % 8) / 2, (s - 1) % 2, x);
            end
         end
      end
      return 3'(v);
   endfunction

   function automatic acc_type sat_acc(input logic signed [AccWidth+1:0] x);
      if (x > $signed({3'b000, {(AccWidth-1){1'b1}}})) return {1'b0, {(AccWidth-1){1'b1}}};
      if (x < $signed({3'b111, {(AccWidth-1){1'b0}}})) return {1'b1, {(AccWidth-1){1'b0}}};
      return x[AccWidth-1:0];
   endfunction

   function automatic pop_type sat_pop(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[PopWidth-1:0];
   endfunction
endpackage
`default_nettype wire

[rtl/emlbc_stream_if.sv]
// ---------------------------------------------------------------------------
// emlbc_stream_if
// valid/ready channel carrying one population transaction
// ---------------------------------------------------------------------------
`default_nettype none
interface emlbc_stream_if;
   logic valid;
   logic ready;
   logic [emlbc_pkg::SlotWidth-1:0] slot;
   logic signed [emlbc_pkg::PopWidth-1:0] value;
   logic [emlbc_pkg::ZWidth-1:0] z;
   logic last;
   modport source(output valid, slot, value, z, last, input ready);
   modport sink(input valid, slot, value, z, last, output ready);
endinterface
`default_nettype wire

[rtl/emlbc_ctrl.sv]
// ---------------------------------------------------------------------------
// emlbc_ctrl
// controller: load, field setup, and emit sequencing
// ---------------------------------------------------------------------------
`default_nettype none
module emlbc_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   input wire logic in_last,
   output logic in_ready,
   input wire logic out_room,
   output emlbc_pkg::cmd_type cmd
);
   localparam logic [1:0] StLoad = 2'd0;
   localparam logic [1:0] StSetup = 2'd1;
   localparam logic [1:0] StRead = 2'd2;
   localparam logic [1:0] StEmit = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [emlbc_pkg::SlotWidth-1:0] slot_ff, slot_in;
   logic [1:0] setup_ff, setup_in;

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      setup_in = setup_ff;
      in_ready = (state_ff == StLoad);
      cmd = '0;
      cmd.slot = slot_ff;
      case (state_ff)
         StLoad: begin
            cmd.load = in_valid;
            if (in_valid && in_last) begin
               state_in = StSetup;
               setup_in = 2'd0;
               slot_in = '0;
            end
         end
         StSetup: begin
            cmd.start = (setup_ff == 2'd0);
            cmd.step = 1'b1;
            setup_in = setup_ff + 2'd1;
            if (setup_ff == 2'd3) state_in = StRead;
         end
         StRead: begin
            state_in = StEmit;
         end
         StEmit: begin
            if (out_room) begin
               cmd.emit = 1'b1;
               if (slot_ff == 6'(emlbc_pkg::NumPop - 1)) begin
                  state_in = StLoad;
               end else begin
                  slot_in = slot_ff + 6'd1;
                  state_in = StRead;
               end
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         slot_ff <= '0;
         setup_ff <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         setup_ff <= setup_in;
      end
   end

   a_emit_only_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == StEmit) else $error("emit outside emit state");
   a_load_only_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> in_ready) else $error("load while busy");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= 6'(emlbc_pkg::NumPop - 1)) else $error("slot out of range");
endmodule
`default_nettype wire

[rtl/emlbc_dp.sv]
// ---------------------------------------------------------------------------
// emlbc_dp
// datapath: population store, accumulators, fields and relaxation
// ---------------------------------------------------------------------------
`default_nettype none
module emlbc_dp (
   input wire logic clock,
   input wire logic reset,
   input wire emlbc_pkg::cmd_type cmd,
   input wire logic [emlbc_pkg::SlotWidth-1:0] in_slot,
   input wire logic signed [emlbc_pkg::PopWidth-1:0] in_value,
   input wire logic [emlbc_pkg::ZWidth-1:0] in_z,
   input wire logic [15:0] inv_lower,
   input wire logic [15:0] inv_upper,
   input wire logic [11:0] iface_z,
   input wire logic [15:0] relax,
   output logic signed [emlbc_pkg::PopWidth-1:0] res_value
);
   logic signed [emlbc_pkg::PopWidth-1:0] store [emlbc_pkg::NumPop];
   logic signed [emlbc_pkg::PopWidth-1:0] rd_ff;
   emlbc_pkg::acc_type eacc_ff [3];
   emlbc_pkg::acc_type bacc_ff [3];
   emlbc_pkg::acc_type qacc_ff;
   emlbc_pkg::pop_type d_ff [3];
   emlbc_pkg::pop_type bf_ff [3];
   emlbc_pkg::pop_type e_ff [3];
   emlbc_pkg::pop_type rho_ff;
   logic [15:0] inv_ff;
   logic [1:0] ax_ff;
   logic [15:0] w_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && in_slot < 6'(emlbc_pkg::NumPop)) store[in_slot] <= in_value;
      rd_ff <= store[cmd.slot];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         for (int a = 0; a < 3; a++) begin
            eacc_ff[a] <= '0;
            bacc_ff[a] <= '0;
         end
         qacc_ff <= '0;
      end else if (cmd.load && in_slot < 6'(emlbc_pkg::NumPop)) begin
         if (in_slot <= 6'd24)
            qacc_ff <= emlbc_pkg::sat_acc(42'(qacc_ff) + 42'(in_value));
         for (int a = 0; a < 3; a++) begin
            if (in_slot >= 6'd1 && in_slot <= 6'd24)
               eacc_ff[a] <= emlbc_pkg::sat_acc(42'(eacc_ff[a]) +
                  42'(emlbc_pkg::coef(in_slot, 1'b0, 2'(a)) * 35'(in_value)));
            else if (in_slot >= 6'd25)
               bacc_ff[a] <= emlbc_pkg::sat_acc(42'(bacc_ff[a]) +
                  42'(emlbc_pkg::coef(in_slot, 1'b1, 2'(a)) * 35'(in_value)));
         end
      end
   end

   // field setup: snapshot then one axis of E per step
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int a = 0; a < 3; a++) begin
            d_ff[a] <= emlbc_pkg::sat_pop(64'(eacc_ff[a] >>> 1));
            bf_ff[a] <= emlbc_pkg::sat_pop(64'(bacc_ff[a] >>> 1));
         end
         rho_ff <= emlbc_pkg::sat_pop(64'(qacc_ff));
         inv_ff <= ((in_z > iface_z) ? inv_upper : inv_lower);
         w_ff <= relax;
         ax_ff <= 2'd0;
      end else if (cmd.step) begin
         e_ff[ax_ff] <= emlbc_pkg::sat_pop(
            (64'(d_ff[ax_ff]) * $signed({48'd0, inv_ff}) + 64'sd8192) >>> 14);
         ax_ff <= ax_ff + 2'd1;
      end
   end

   logic signed [63:0] de, db, num, acc;
   logic is_mag;
   always_comb begin
      is_mag = cmd.slot >= 6'd25;
      de = '0;
      db = '0;
      for (int a = 0; a < 3; a++) begin
         de = de + 64'(emlbc_pkg::coef(cmd.slot, 1'b0, 2'(a))) *
            64'(is_mag ? e_ff[a] : d_ff[a]);
         db = db + 64'(emlbc_pkg::coef(cmd.slot, 1'b1, 2'(a))) * 64'(bf_ff[a]);
      end
      num = 2 * de + db;
      if (cmd.slot == 6'd0)
         acc = (64'(rd_ff) * 64'sd16384 + $signed({48'd0, w_ff}) *
            (64'(rho_ff) - 64'(rd_ff)) + 64'sd8192) >>> 14;
      else
         acc = (64'(rd_ff) * 64'sd262144 + $signed({48'd0, w_ff}) *
            (num - 64'(rd_ff) * 64'sd16) + 64'sd131072) >>> 18;
      res_value = emlbc_pkg::sat_pop(acc);
   end
endmodule
`default_nettype wire

[rtl/em_lattice_boltzmann_cell_collision.sv]
// ---------------------------------------------------------------------------
// em_lattice_boltzmann_cell_collision
// electromagnetic lattice-Boltzmann BGK collision for one cell
// ---------------------------------------------------------------------------
// a cell loads its 49 populations, runs field setup, then each result passes
// a store read state and an emit state (store read, then output register); emit waits while the output is full
// the controller's read/emit alternation and output back-pressure set the emit pace
// synchronous reset restores register defaults and clears accumulators
`default_nettype none
module em_lattice_boltzmann_cell_collision (
   input wire logic clock,
   input wire logic reset,
   emlbc_stream_if.sink req,
   emlbc_stream_if.source rsp,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [emlbc_pkg::AddrWidth-1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [15:0] inv_lower_ff, inv_upper_ff, relax_ff;
   logic [11:0] iface_ff;
   logic [emlbc_pkg::ZWidth-1:0] z_ff;
   emlbc_pkg::cmd_type cmd;
   logic signed [31:0] res_value;
   logic out_room;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_lower_ff <= 16'd16384;
         inv_upper_ff <= 16'd6554;
         iface_ff <= 12'd50;
         relax_ff <= 16'd32768;
      end else if (wr) begin
         case (csr_paddr)
            emlbc_pkg::RegInvPermLower: inv_lower_ff <= csr_pwdata[15:0];
            emlbc_pkg::RegInvPermUpper: inv_upper_ff <= csr_pwdata[15:0];
            emlbc_pkg::RegInterfaceZ: iface_ff <= csr_pwdata[11:0];
            emlbc_pkg::RegRelaxRate: relax_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         emlbc_pkg::RegInvPermLower: csr_prdata = {16'd0, inv_lower_ff};
         emlbc_pkg::RegInvPermUpper: csr_prdata = {16'd0, inv_upper_ff};
         emlbc_pkg::RegInterfaceZ: csr_prdata = {20'd0, iface_ff};
         emlbc_pkg::RegRelaxRate: csr_prdata = {16'd0, relax_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.last) z_ff <= req.z;
   end

   assign out_room = !rsp.valid || rsp.ready;

   emlbc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_last(req.last),
      .in_ready(req.ready), .out_room(out_room), .cmd(cmd)
   );

   emlbc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_slot(req.slot),
      .in_value(req.value), .in_z(z_ff), .inv_lower(inv_lower_ff),
      .inv_upper(inv_upper_ff), .iface_z(iface_ff), .relax(relax_ff),
      .res_value(res_value)
   );

   logic valid_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.emit) valid_ff <= 1'b1;
      else if (rsp.ready) valid_ff <= 1'b0;
      if (cmd.emit) begin
         rsp.value <= res_value;
         rsp.slot <= cmd.slot;
         rsp.last <= (cmd.slot == 6'(emlbc_pkg::NumPop - 1));
      end
   end
   assign rsp.valid = valid_ff;
   assign rsp.z = '0;
endmodule
`default_nettype wire
